// ----- design/psgc_pkg.sv -----
// ----------------------------------------------------------------------------
// psgc_pkg
// Shared widths, angle constants and the CORDIC arctangent table for the
// phase-shift / Gray-code unwrap pipeline.
// ----------------------------------------------------------------------------
package psgc_pkg;

  localparam int PIX_W        = 8;
  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_STEPS   = 15;
  localparam int XY_W         = 28;
  localparam int Z_W          = 35;
  localparam int ROOT_W       = 15;
  localparam int REM_W        = 30;
  localparam int ROUND_SH     = 18;   // Q30 down to 12 fractional bits

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint RND_HALF    = 64'sd131072;
  localparam longint RND_DIV     = 64'sd262144;

  localparam logic signed [16:0] PI_LIM  = 17'((PI_Q30 + RND_HALF) / RND_DIV);
  localparam logic signed [16:0] HALF_PI = 17'((HALF_PI_Q30 + RND_HALF) / RND_DIV);
  localparam logic signed [16:0] TWO_PI  = 17'((TWO_PI_Q30 + RND_HALF) / RND_DIV);

  localparam logic signed [XY_W-1:0] SQRT3_Q14 = XY_W'(28378);
  localparam logic [15:0] RECIP6 = 16'd43691;  // 2^18 / 6, rounded up

  typedef struct packed {
    logic [11:0]       avg;
    logic [3:0]        k1;
    logic [4:0]        k2;
    logic              zero;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(843314857);
      1:  v = Z_W'(497837829);
      2:  v = Z_W'(263043837);
      3:  v = Z_W'(133525159);
      4:  v = Z_W'(67021687);
      5:  v = Z_W'(33543516);
      6:  v = Z_W'(16775851);
      7:  v = Z_W'(8388437);
      8:  v = Z_W'(4194283);
      9:  v = Z_W'(2097149);
      10: v = Z_W'(1048576);
      11: v = Z_W'(524288);
      12: v = Z_W'(262144);
      13: v = Z_W'(131072);
      14: v = Z_W'(65536);
      15: v = Z_W'(32768);
      16: v = Z_W'(16384);
      17: v = Z_W'(8192);
      18: v = Z_W'(4096);
      19: v = Z_W'(2048);
      20: v = Z_W'(1024);
      21: v = Z_W'(512);
      22: v = Z_W'(256);
      23: v = Z_W'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/psgc_cordic.sv -----
// ----------------------------------------------------------------------------
// psgc_cordic
// Vectoring-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module psgc_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [psgc_pkg::XY_W-1:0]  x_in,
  input  logic signed [psgc_pkg::XY_W-1:0]  y_in,
  input  logic signed [psgc_pkg::Z_W-1:0]   z_in,
  output logic signed [psgc_pkg::Z_W-1:0]   z_out
);
  import psgc_pkg::*;

  logic signed [XY_W-1:0] xr [CORDIC_ITERS];
  logic signed [XY_W-1:0] yr [CORDIC_ITERS];
  logic signed [Z_W-1:0]  zr [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    logic signed [XY_W-1:0] xi, yi;
    logic signed [Z_W-1:0]  zi;
    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          xr[i] <= xi + (yi >>> i);
          yr[i] <= yi - (xi >>> i);
          zr[i] <= zi + atan_q30(i);
        end else begin
          xr[i] <= xi - (yi >>> i);
          yr[i] <= yi + (xi >>> i);
          zr[i] <= zi - atan_q30(i);
        end
      end
    end
  end

  assign z_out = zr[CORDIC_ITERS-1];

endmodule

// ----- design/phase_shift_gray_code_unwrap.sv -----
// ----------------------------------------------------------------------------
// phase_shift_gray_code_unwrap
// Per-pixel three-step phase shift with complementary Gray-code unwrapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel: three phase-shifted
//   intensities and five Gray-code intensities. Output channel
//   (out_valid/out_ready) returns one transaction per pixel: absolute phase,
//   wrapped phase, average, modulation and the modulation-valid flag.
//   The pipeline has four front stages (input capture, differences,
//   products, pre-rotation), 24 CORDIC stages with the square root riding
//   alongside, then two finishing stages. Throughput is one pixel per cycle.
//   The pipeline advances as a whole whenever the output register is empty
//   or being taken; when the receiver stalls with a result waiting, every
//   stage holds and in_ready drops, so nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the modulation threshold
//   with 5.0 (80 in 4 fractional bits). Write the threshold through
//   cfg_wr_en/cfg_wr_data only while the pipeline is empty.
// ----------------------------------------------------------------------------
module phase_shift_gray_code_unwrap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psgc_pkg::PIX_W-1:0]  shift0,
  input  logic [psgc_pkg::PIX_W-1:0]  shift1,
  input  logic [psgc_pkg::PIX_W-1:0]  shift2,
  input  logic [psgc_pkg::PIX_W-1:0]  gray0,
  input  logic [psgc_pkg::PIX_W-1:0]  gray1,
  input  logic [psgc_pkg::PIX_W-1:0]  gray2,
  input  logic [psgc_pkg::PIX_W-1:0]  gray3,
  input  logic [psgc_pkg::PIX_W-1:0]  gray4,
  input  logic                        cfg_wr_en,
  input  logic [11:0]                 cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [19:0]          abs_phase,
  output logic signed [14:0]          wrapped_phase,
  output logic [11:0]                 average,
  output logic [11:0]                 modulation,
  output logic                        valid_res
);
  import psgc_pkg::*;

  localparam int LAT = 4 + CORDIC_ITERS + 2;

  logic [LAT-1:0] vld;
  logic           en;
  logic [11:0]    threshold;

  // Advance everything when the output slot is free or being taken.
  assign en       = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      threshold <= 12'd80;
    end else begin
      if (en) begin
        vld <= {vld[LAT-2:0], in_valid};
      end
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
    end
  end

  // Stage 1: capture the pixel
  logic [PIX_W-1:0] a1, b1, c1;
  logic [PIX_W-1:0] g1 [5];

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= shift0;
      b1 <= shift1;
      c1 <= shift2;
      g1[0] <= gray0;
      g1[1] <= gray1;
      g1[2] <= gray2;
      g1[3] <= gray3;
      g1[4] <= gray4;
    end
  end

  // Stage 2: differences, sum and Gray thresholds against the exact mean
  logic [9:0]         sum_c;
  logic signed [9:0]  d_c;
  logic signed [10:0] e_c;
  logic [4:0]         gb_c;

  always_comb begin
    sum_c = 10'(a1) + 10'(b1) + 10'(c1);
    d_c   = $signed(10'(a1)) - $signed(10'(c1));
    e_c   = $signed({2'b00, b1, 1'b0}) - $signed(11'(a1)) - $signed(11'(c1));
    for (int i = 0; i < 5; i++) begin
      gb_c[i] = (10'(g1[i]) * 10'd3) >= sum_c;
    end
  end

  logic [9:0]         sum2;
  logic signed [9:0]  d2;
  logic signed [10:0] e2;
  logic [4:0]         gb2;

  always_ff @(posedge clk) begin
    if (en) begin
      sum2 <= sum_c;
      d2   <= d_c;
      e2   <= e_c;
      gb2  <= gb_c;
    end
  end

  // Stage 3: products and Gray-to-binary
  logic signed [XY_W-1:0] d_ext, e_ext;
  logic signed [20:0]     dsq, esq;
  logic [4:0]             v5_c;

  always_comb begin
    d_ext = XY_W'(d2);
    e_ext = XY_W'(e2);
    dsq   = 21'(d2);
    esq   = 21'(e2);
    v5_c[4] = gb2[0];
    for (int i = 1; i < 5; i++) begin
      v5_c[4-i] = v5_c[5-i] ^ gb2[i];
    end
  end

  logic signed [XY_W-1:0] x3, y3;
  logic [20:0]            s3;
  logic [31:0]            avgp3;
  logic [3:0]             k1_3;
  logic [4:0]             k2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      y3    <= d_ext * SQRT3_Q14;
      x3    <= e_ext <<< 14;
      s3    <= 21'(dsq * dsq * 21'sd3 + esq * esq);
      avgp3 <= (32'(sum2) * 32'd32 + 32'd3) * 32'(RECIP6);
      k1_3  <= v5_c[4:1];
      k2_3  <= 5'((6'(v5_c) + 6'd1) >> 1);
    end
  end

  // Stage 4: turn by pi for the left half plane, finish the average
  logic signed [XY_W-1:0] x4, y4;
  logic signed [Z_W-1:0]  z4;
  side_t                  side4;

  always_ff @(posedge clk) begin
    if (en) begin
      if (x3 < 0) begin
        x4 <= -x3;
        y4 <= -y3;
        z4 <= (y3 >= 0) ? Z_W'(PI_Q30) : -Z_W'(PI_Q30);
      end else begin
        x4 <= x3;
        y4 <= y3;
        z4 <= '0;
      end
      side4.avg  <= (avgp3[31:18] > 14'd4095) ? 12'd4095 : avgp3[29:18];
      side4.k1   <= k1_3;
      side4.k2   <= k2_3;
      side4.zero <= (x3 == 0) && (y3 == 0);
      side4.rem  <= REM_W'(s3) << 10;
      side4.root <= '0;
    end
  end

  // CORDIC stages; the square root advances one bit per stage over the first SQRT_STEPS of them
  logic signed [Z_W-1:0] zc;

  psgc_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (x4),
    .y_in  (y4),
    .z_in  (z4),
    .z_out (zc)
  );

  side_t side [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_side
    side_t si;
    side_t so;
    if (i == 0) begin : g_first
      assign si = side4;
    end else begin : g_next
      assign si = side[i-1];
    end

    if (i < SQRT_STEPS) begin : g_sqrt
      localparam int J = SQRT_STEPS - 1 - i;
      logic [REM_W-1:0] cand;
      always_comb begin
        cand = (REM_W'(si.root) << (J + 1)) + (REM_W'(1) << (2 * J));
        so   = si;
        if (si.rem >= cand) begin
          so.rem  = si.rem - cand;
          so.root = si.root | (ROOT_W'(1) << J);
        end
      end
    end else begin : g_hold
      assign so = si;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i] <= so;
      end
    end
  end

  // Finish 1: round and clamp the angle, scale the root by 1/6
  side_t              last;
  logic signed [16:0] zr_c;
  logic signed [14:0] wr_c;

  assign last = side[CORDIC_ITERS-1];

  always_comb begin
    zr_c = 17'((zc + Z_W'(RND_HALF)) >>> ROUND_SH);
    if (last.zero) begin
      wr_c = '0;
    end else if (zr_c > PI_LIM) begin
      wr_c = 15'(PI_LIM);
    end else if (zr_c < -PI_LIM) begin
      wr_c = 15'(-PI_LIM);
    end else begin
      wr_c = 15'(zr_c);
    end
  end

  logic signed [14:0] wr5;
  logic [31:0]        modp5;
  logic [11:0]        avg5;
  logic [3:0]         k1_5;
  logic [4:0]         k2_5;

  always_ff @(posedge clk) begin
    if (en) begin
      wr5   <= wr_c;
      modp5 <= (32'(last.root) + 32'd3) * 32'(RECIP6);
      avg5  <= last.avg;
      k1_5  <= last.k1;
      k2_5  <= last.k2;
    end
  end

  // Finish 2: threshold test and fringe-order offset
  logic [13:0]        mod_raw;
  logic [11:0]        mod_c;
  logic               ok_c;
  logic signed [5:0]  km_c;
  logic signed [16:0] w17;
  logic signed [22:0] abs_c;

  always_comb begin
    mod_raw = modp5[31:18];
    mod_c   = (mod_raw > 14'd4095) ? 12'd4095 : mod_raw[11:0];
    ok_c    = mod_c > threshold;
    w17     = 17'(wr5);
    if (w17 <= -HALF_PI) begin
      km_c = $signed(6'(k2_5));
    end else if (w17 >= HALF_PI) begin
      km_c = $signed(6'(k2_5)) - 6'sd1;
    end else begin
      km_c = $signed(6'(k1_5));
    end
    abs_c = 23'(w17) + 23'(TWO_PI) * 23'(km_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_phase     <= ok_c ? 20'(abs_c) : '0;
      wrapped_phase <= wr5;
      average       <= avg5;
      modulation    <= mod_c;
      valid_res     <= ok_c;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case pixels into the phase-shift / Gray-code
// unwrap pipeline and checks every output transaction against a local model.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [19:0] abs_phase;
  logic signed [14:0] wrapped_phase;
  logic [11:0]        average;
  logic [11:0]        modulation;
  logic               valid_res;
} pixel_result_t;

class pixel_scoreboard;
  pixel_result_t pending[$];
  logic [11:0]   mod_threshold;
  int            errors;

  function new();
    mod_threshold = 12'd80;
    errors = 0;
  endfunction

  // floor division by 2^s for a signed value
  static function longint sra(longint v, int s);
    return v >>> s;
  endfunction

  static function longint round_angle(longint v);
    return sra(v + 64'sd131072, 18);
  endfunction

  static function longint int_sqrt(longint v);
    longint r, bit_v;
    r = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >>> 1) + bit_v;
      end else begin
        r = r >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return r;
  endfunction

  static function longint cordic_phase(longint y, longint x);
    longint z, dx, dy, w, lim;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? psgc_pkg::PI_Q30 : -psgc_pkg::PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + longint'(psgc_pkg::atan_q30(i));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(psgc_pkg::atan_q30(i));
      end
    end
    w = round_angle(z);
    lim = round_angle(psgc_pkg::PI_Q30);
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    return w;
  endfunction

  // note an accepted pixel: compute and queue its expected result
  function void note_pixel(logic [7:0] s0, s1, s2, logic [7:0] g [5]);
    longint a, b, c, sum, d, e, avg, md, wr, hp, tp, ph, v5, bitv, k1, k2;
    pixel_result_t r;
    a = s0; b = s1; c = s2;
    sum = a + b + c;
    d = a - c;
    e = 2 * b - a - c;
    avg = (sum * 32 + 3) / 6;
    if (avg > 4095) avg = 4095;
    md = (int_sqrt((3 * d * d + e * e) * 1024) + 3) / 6;
    if (md > 4095) md = 4095;
    wr = cordic_phase(d * 28378, e * 16384);
    v5 = 0; bitv = 0;
    for (int i = 0; i < 5; i++) begin
      bitv = bitv ^ ((longint'(g[i]) * 3 >= sum) ? 1 : 0);
      v5 = (v5 << 1) | bitv;
    end
    k1 = v5 >> 1;
    k2 = (v5 + 1) >> 1;
    hp = round_angle(psgc_pkg::HALF_PI_Q30);
    tp = round_angle(psgc_pkg::TWO_PI_Q30);
    if (wr <= -hp) ph = wr + tp * k2;
    else if (wr >= hp) ph = wr + tp * (k2 - 1);
    else ph = wr + tp * k1;
    r.valid_res = md > longint'(mod_threshold);
    if (!r.valid_res) ph = 0;
    r.abs_phase = ph[19:0];
    r.wrapped_phase = wr[14:0];
    r.average = avg[11:0];
    r.modulation = md[11:0];
    pending.push_back(r);
  endfunction

  function void check_result(pixel_result_t got);
    pixel_result_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result abs_phase %0d", $realtime, got.abs_phase);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.abs_phase !== exp_r.abs_phase) begin
      $display("%0t: abs_phase expected %0d got %0d", $realtime, exp_r.abs_phase,
               got.abs_phase);
      errors++;
    end
    if (got.wrapped_phase !== exp_r.wrapped_phase) begin
      $display("%0t: wrapped_phase expected %0d got %0d", $realtime,
               exp_r.wrapped_phase, got.wrapped_phase);
      errors++;
    end
    if (got.average !== exp_r.average) begin
      $display("%0t: average expected %0d got %0d", $realtime, exp_r.average,
               got.average);
      errors++;
    end
    if (got.modulation !== exp_r.modulation) begin
      $display("%0t: modulation expected %0d got %0d", $realtime, exp_r.modulation,
               got.modulation);
      errors++;
    end
    if (got.valid_res !== exp_r.valid_res) begin
      $display("%0t: valid_res expected %0d got %0d", $realtime, exp_r.valid_res,
               got.valid_res);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY   = 30;
  localparam int WATCH_MAX = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] shift0 = '0, shift1 = '0, shift2 = '0;
  logic [7:0] gray0 = '0, gray1 = '0, gray2 = '0, gray3 = '0, gray4 = '0;
  logic cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [19:0] abs_phase;
  logic signed [14:0] wrapped_phase;
  logic [11:0] average, modulation;
  logic valid_res;

  // idle percentages, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  pixel_scoreboard unwrap_sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  phase_shift_gray_code_unwrap i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .shift0(shift0), .shift1(shift1), .shift2(shift2),
    .gray0(gray0), .gray1(gray1), .gray2(gray2), .gray3(gray3), .gray4(gray4),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .abs_phase(abs_phase), .wrapped_phase(wrapped_phase),
    .average(average), .modulation(modulation), .valid_res(valid_res)
  );

  // Receiver side: check each output transaction, then pick next ready.
  always @(posedge clk) begin
    pixel_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.abs_phase = abs_phase;
        got.wrapped_phase = wrapped_phase;
        got.average = average;
        got.modulation = modulation;
        got.valid_res = valid_res;
        unwrap_sb.check_result(got);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_MAX) begin
        $display("phase_shift_gray_code_unwrap verification failed");
        $finish;
      end
    end
  end

  // Send one pixel: apply random sender gaps, hold until accepted.
  // Called at a rising edge; leaves valid up so the next call can follow
  // without a gap. Callers that stop sending drop valid themselves.
  task automatic send_pixel(input logic [7:0] s0, s1, s2, g0, g1, g2, g3, g4);
    logic [7:0] g [5];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    shift0 <= s0; shift1 <= s1; shift2 <= s2;
    gray0 <= g0; gray1 <= g1; gray2 <= g2; gray3 <= g3; gray4 <= g4;
    g[0] = g0; g[1] = g1; g[2] = g2; g[3] = g3; g[4] = g4;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge; note before anything else moves
    unwrap_sb.note_pixel(s0, s1, s2, g);
  endtask

  // Wait for the pipeline to drain, then write the threshold.
  task automatic drain_and_set(input logic [11:0] thr);
    in_valid <= 1'b0;
    while (unwrap_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unwrap_sb.mod_threshold = thr;
  endtask

  // Random pixel: mostly a plausible fringe with Gray levels around the mean.
  task automatic send_random_pixel();
    logic [7:0] s [3];
    logic [7:0] g [5];
    int mean;
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 3; i++) s[i] = 8'($urandom);
      for (int i = 0; i < 5; i++) g[i] = 8'($urandom);
    end else begin
      for (int i = 0; i < 3; i++) s[i] = 8'($urandom);
      mean = (s[0] + s[1] + s[2]) / 3;
      for (int i = 0; i < 5; i++) begin
        if ($urandom_range(1)) g[i] = 8'(mean + $urandom_range(255 - mean));
        else g[i] = 8'($urandom_range(mean));
      end
    end
    send_pixel(s[0], s[1], s[2], g[0], g[1], g[2], g[3], g[4]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero vector, quadrant borders, Gray thresholds.
    send_pixel(0, 0, 0, 0, 0, 0, 0, 0);
    send_pixel(255, 255, 255, 255, 255, 255, 255, 255);
    send_pixel(100, 100, 100, 99, 100, 101, 100, 0);
    send_pixel(255, 0, 0, 255, 0, 255, 0, 255);
    send_pixel(0, 0, 255, 0, 255, 0, 255, 0);
    send_pixel(0, 255, 0, 85, 84, 86, 85, 255);
    send_pixel(255, 0, 255, 170, 171, 169, 255, 0);
    send_pixel(128, 255, 128, 255, 255, 255, 255, 255);
    send_pixel(200, 50, 10, 0, 255, 0, 255, 0);
    send_pixel(10, 50, 200, 255, 255, 0, 0, 255);
    send_pixel(0, 128, 255, 128, 127, 128, 127, 128);
    send_pixel(255, 128, 0, 127, 128, 127, 128, 127);
    send_pixel(101, 100, 100, 255, 0, 0, 0, 0);
    send_pixel(100, 100, 101, 0, 0, 0, 0, 255);
    send_pixel(1, 0, 0, 0, 0, 0, 0, 1);
    send_pixel(170, 85, 0, 85, 85, 85, 85, 85);

    // Threshold extremes, then random phases with different idling.
    drain_and_set(12'd0);
    send_pixel(101, 100, 100, 255, 255, 255, 255, 255);
    send_pixel(50, 50, 50, 0, 0, 0, 0, 0);
    drain_and_set(12'd4095);
    send_pixel(255, 0, 0, 255, 0, 255, 0, 255);
    send_pixel(0, 255, 0, 255, 255, 255, 255, 255);
    drain_and_set(12'd80);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 110; n++) send_random_pixel();
      if (ph == 1) drain_and_set(12'($urandom_range(300)));
      if (ph == 2) drain_and_set(12'd4095);
      if (ph == 3) drain_and_set(12'd0);
    end

    // Final drain, then settle for the pipeline depth.
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (unwrap_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (unwrap_sb.errors == 0 && unwrap_sb.pending.size() == 0) begin
      $display("phase_shift_gray_code_unwrap verification clean");
    end else begin
      $display("phase_shift_gray_code_unwrap verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/psgc_pkg.sv
design/psgc_cordic.sv
design/phase_shift_gray_code_unwrap.sv
bench/testbench.sv
